/* rtl/sha_pkg.sv */
// ----------------------------------------------------------------------------
// sha_pkg: shared types, constants and functions for the SHA-256 stream hash
// Round constants, initial hash value, sigma functions and control structs.
// ----------------------------------------------------------------------------
package sha_pkg;

   typedef logic [31:0] word_type;
   typedef word_type [0:7] hash_type;

   localparam int unsigned BlockWords  = 16;
   localparam int unsigned DigestWords = 8;

   localparam logic [2:0] MaxByteCount = 3'd4;
   localparam logic [7:0] PadByte      = 8'h80;
   localparam logic [5:0] LenStartPos  = 6'd55;
   localparam logic [5:0] BlockEndPos  = 6'd63;
   localparam logic [5:0] LastRound    = 6'd63;
   localparam logic [2:0] LastLenByte  = 3'd7;
   localparam logic [2:0] LastDigestIx = 3'd7;

   localparam word_type RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam hash_type InitHash = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef struct packed {
      logic       wr_en;
      logic [5:0] wr_pos;
      logic [7:0] wr_byte;
      logic       shift;
   } sched_ctrl_type;

   typedef struct packed {
      logic load;
      logic step;
      logic fold;
      logic init;
   } core_ctrl_type;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_DATA = 8'b0000_0010,
      ST_PAD  = 8'b0000_0100,
      ST_ZERO = 8'b0000_1000,
      ST_LEN  = 8'b0001_0000,
      ST_COMP = 8'b0010_0000,
      ST_FOLD = 8'b0100_0000,
      ST_EMIT = 8'b1000_0000
   } seq_state_type;

   function automatic word_type big_sigma0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

/* rtl/sha_req_if.sv */
// ----------------------------------------------------------------------------
// sha_req_if: message word channel
// Valid/ready channel carrying up to four message bytes and a last flag.
// ----------------------------------------------------------------------------
interface sha_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;
   logic [2:0]  byte_count;
   logic        last;

   modport source (output valid, output data_word, output byte_count, output last,
                   input ready);
   modport sink   (input valid, input data_word, input byte_count, input last,
                   output ready);
endinterface

/* rtl/sha_rsp_if.sv */
// ----------------------------------------------------------------------------
// sha_rsp_if: digest word channel
// Valid/ready channel carrying one digest word, its index and a last flag.
// ----------------------------------------------------------------------------
interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        digest_last;

   modport source (output valid, output digest_word, output word_index,
                   output digest_last, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input digest_last, output ready);
endinterface

/* rtl/sha_sched.sv */
// ----------------------------------------------------------------------------
// sha_sched: block buffer and message schedule window
// Sixteen-word window, filled one byte per cycle while wr_en is high, then
// shifted once per round with the next schedule word entering at the top.
// ----------------------------------------------------------------------------
module sha_sched (
   input  logic                    clock,
   input  sha_pkg::sched_ctrl_type ctrl,
   output sha_pkg::word_type       w_word
);

   sha_pkg::word_type w_ff [sha_pkg::BlockWords];
   sha_pkg::word_type w_in [sha_pkg::BlockWords];
   sha_pkg::word_type w_next;

   assign w_next = sha_pkg::small_sigma1(w_ff[14]) + w_ff[9]
                 + sha_pkg::small_sigma0(w_ff[1]) + w_ff[0];

   always_comb begin
      w_in = w_ff;
      if (ctrl.shift) begin
         for (int i = 0; i < sha_pkg::BlockWords - 1; i++) begin
            w_in[i] = w_ff[i + 1];
         end
         w_in[sha_pkg::BlockWords - 1] = w_next;
      end else if (ctrl.wr_en) begin
         w_in[ctrl.wr_pos[5:2]][{~ctrl.wr_pos[1:0], 3'b000} +: 8] = ctrl.wr_byte;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
   end

   assign w_word = w_ff[0];

endmodule

/* rtl/sha_core.sv */
// ----------------------------------------------------------------------------
// sha_core: compression round unit and chain value
// One SHA-256 round per cycle on the working variables while step is high,
// plus their load from the chain, the final chain update and its init.
// ----------------------------------------------------------------------------
module sha_core (
   input  logic                   clock,
   input  logic                   reset,
   input  sha_pkg::core_ctrl_type ctrl,
   input  sha_pkg::word_type      w_word,
   input  logic [5:0]             round_idx,
   output sha_pkg::hash_type      chain
);

   sha_pkg::hash_type chain_ff, chain_in;
   sha_pkg::hash_type v_ff, v_in;
   sha_pkg::word_type t1, t2, ch, maj;

   assign ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t1  = v_ff[7] + sha_pkg::big_sigma1(v_ff[4]) + ch
              + sha_pkg::RoundK[round_idx] + w_word;
   assign t2  = sha_pkg::big_sigma0(v_ff[0]) + maj;

   always_comb begin
      v_in = v_ff;
      if (ctrl.load) begin
         v_in = chain_ff;
      end else if (ctrl.step) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
      end
   end

   always_comb begin
      chain_in = chain_ff;
      if (ctrl.init) begin
         chain_in = sha_pkg::InitHash;
      end else if (ctrl.fold) begin
         for (int i = 0; i < sha_pkg::DigestWords; i++) begin
            chain_in[i] = chain_ff[i] + v_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= sha_pkg::InitHash;
      end else begin
         chain_ff <= chain_in;
      end
   end

   assign chain = chain_ff;

endmodule

/* rtl/sha256_stream_hash.sv */
// ----------------------------------------------------------------------------
// sha256_stream_hash: SHA-256 over a byte stream, digest out as eight words
// Sequencer that loads bytes into the block window, pads the final block and
// drives the shared round unit.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                  transfer
//  req_chan  in   data_word[31:0] byte_count[2:0] last     valid & ready
//  rsp_chan  out  digest_word[31:0] word_index[2:0]
//                 digest_last                              valid & ready
//
//  Each accepted item writes its valid bytes (byte_count above 4 counts as 4)
//  into the window one per cycle, pausing while a full block is compressed.
//  Each full 64-byte block is compressed in 64 rounds on the one round unit,
//  followed by one chain update.
//  A last item adds padding (one byte per cycle between compressions) to the
//  length field, 8 length bytes, one or two compressions, then 8 digest transfers.
//  Synchronous reset loads the initial hash value and clears length and fill.
//  rsp_chan stalls hold the digest word; req_chan.ready is low until done.
// ----------------------------------------------------------------------------
module sha256_stream_hash (
   input  logic clock,
   input  logic reset,
   sha_req_if.sink   req_chan,
   sha_rsp_if.source rsp_chan
);

   sha_pkg::seq_state_type state_ff, state_in;
   sha_pkg::seq_state_type ret_ff, ret_in;
   sha_pkg::seq_state_type nxt_phase;

   logic [31:0] word_ff, word_in;
   logic [2:0]  count_ff, count_in;
   logic        last_ff, last_in;
   logic [2:0]  byte_idx_ff, byte_idx_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] msg_bytes_ff, msg_bytes_in;
   logic [5:0]  round_ff, round_in;
   logic [2:0]  out_idx_ff, out_idx_in;

   logic        req_xfer, rsp_xfer;
   logic [2:0]  count_sat;
   logic [63:0] len_bits;
   logic        push_en;
   logic [7:0]  push_byte;
   logic        block_full;

   sha_pkg::sched_ctrl_type sched_ctrl;
   sha_pkg::core_ctrl_type  core_ctrl;
   sha_pkg::word_type       w_word;
   sha_pkg::hash_type       chain;

   assign req_chan.ready = (state_ff == sha_pkg::ST_IDLE);
   assign rsp_chan.valid = (state_ff == sha_pkg::ST_EMIT);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign rsp_xfer       = rsp_chan.valid && rsp_chan.ready;

   assign rsp_chan.digest_word = chain[out_idx_ff];
   assign rsp_chan.word_index  = out_idx_ff;
   assign rsp_chan.digest_last = (out_idx_ff == sha_pkg::LastDigestIx);

   assign count_sat = (req_chan.byte_count > sha_pkg::MaxByteCount) ?
                      sha_pkg::MaxByteCount : req_chan.byte_count;
   assign len_bits  = {msg_bytes_ff[60:0], 3'b000};

   always_comb begin
      push_en   = 1'b0;
      push_byte = 8'h00;
      unique case (state_ff)
         sha_pkg::ST_DATA: begin
            push_en   = 1'b1;
            push_byte = word_ff[{~byte_idx_ff[1:0], 3'b000} +: 8];
         end
         sha_pkg::ST_PAD: begin
            push_en   = 1'b1;
            push_byte = sha_pkg::PadByte;
         end
         sha_pkg::ST_ZERO: begin
            push_en   = 1'b1;
         end
         sha_pkg::ST_LEN: begin
            push_en   = 1'b1;
            push_byte = len_bits[{~byte_idx_ff, 3'b000} +: 8];
         end
         default: begin
            push_en   = 1'b0;
         end
      endcase
   end

   assign block_full = push_en && (fill_ff == sha_pkg::BlockEndPos);

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      nxt_phase    = state_ff;
      word_in      = word_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      byte_idx_in  = byte_idx_ff;
      fill_in      = push_en ? fill_ff + 6'd1 : fill_ff;
      msg_bytes_in = msg_bytes_ff;
      round_in     = round_ff;
      out_idx_in   = out_idx_ff;
      core_ctrl    = '0;

      unique case (state_ff) inside
         sha_pkg::ST_IDLE: begin
            if (req_xfer) begin
               word_in      = req_chan.data_word;
               count_in     = count_sat;
               last_in      = req_chan.last;
               byte_idx_in  = 3'd0;
               msg_bytes_in = msg_bytes_ff + {61'd0, count_sat};
               if (count_sat != 3'd0) begin
                  state_in = sha_pkg::ST_DATA;
               end else if (req_chan.last) begin
                  state_in = sha_pkg::ST_PAD;
               end
            end
         end
         sha_pkg::ST_DATA: begin
            if (byte_idx_ff == count_ff - 3'd1) begin
               byte_idx_in = 3'd0;
               nxt_phase   = last_ff ? sha_pkg::ST_PAD : sha_pkg::ST_IDLE;
            end else begin
               byte_idx_in = byte_idx_ff + 3'd1;
               nxt_phase   = sha_pkg::ST_DATA;
            end
         end
         sha_pkg::ST_PAD, sha_pkg::ST_ZERO: begin
            nxt_phase = (fill_ff == sha_pkg::LenStartPos) ? sha_pkg::ST_LEN
                                                          : sha_pkg::ST_ZERO;
         end
         sha_pkg::ST_LEN: begin
            byte_idx_in = byte_idx_ff + 3'd1;
            nxt_phase   = (byte_idx_ff == sha_pkg::LastLenByte) ? sha_pkg::ST_EMIT
                                                                : sha_pkg::ST_LEN;
         end
         sha_pkg::ST_COMP: begin
            core_ctrl.step = 1'b1;
            round_in       = round_ff + 6'd1;
            if (round_ff == sha_pkg::LastRound) begin
               state_in = sha_pkg::ST_FOLD;
            end
         end
         sha_pkg::ST_FOLD: begin
            core_ctrl.fold = 1'b1;
            state_in       = ret_ff;
         end
         sha_pkg::ST_EMIT: begin
            if (rsp_xfer) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == sha_pkg::LastDigestIx) begin
                  core_ctrl.init = 1'b1;
                  msg_bytes_in   = 64'd0;
                  fill_in        = 6'd0;
                  state_in       = sha_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sha_pkg::ST_IDLE;
         end
      endcase

      if (push_en) begin
         if (block_full) begin
            core_ctrl.load = 1'b1;
            round_in       = 6'd0;
            ret_in         = nxt_phase;
            state_in       = sha_pkg::ST_COMP;
         end else begin
            state_in = nxt_phase;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sha_pkg::ST_IDLE;
         ret_ff       <= sha_pkg::ST_IDLE;
         byte_idx_ff  <= 3'd0;
         fill_ff      <= 6'd0;
         msg_bytes_ff <= 64'd0;
         round_ff     <= 6'd0;
         out_idx_ff   <= 3'd0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         byte_idx_ff  <= byte_idx_in;
         fill_ff      <= fill_in;
         msg_bytes_ff <= msg_bytes_in;
         round_ff     <= round_in;
         out_idx_ff   <= out_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      count_ff <= count_in;
      last_ff  <= last_in;
   end

   assign sched_ctrl.wr_en   = push_en;
   assign sched_ctrl.wr_pos  = fill_ff;
   assign sched_ctrl.wr_byte = push_byte;
   assign sched_ctrl.shift   = (state_ff == sha_pkg::ST_COMP);

   sha_sched u_sched (
      .clock  (clock),
      .ctrl   (sched_ctrl),
      .w_word (w_word)
   );

   sha_core u_core (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (core_ctrl),
      .w_word    (w_word),
      .round_idx (round_ff),
      .chain     (chain)
   );

endmodule

/* rtl/sha_check.sv */
// ----------------------------------------------------------------------------
// sha_check: port-level checks for the SHA-256 stream hash
// Digest sequencing, stall hold and channel exclusivity, bound to the top level.
// ----------------------------------------------------------------------------
module sha_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] digest_word,
   input logic [2:0]  word_index,
   input logic        digest_last
);

   logic rsp_xfer;

   assign rsp_xfer = rsp_valid && rsp_ready;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while digest pending");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (digest_last == (word_index == 3'd7)))
      else $error("digest_last does not match word_index");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && !digest_last) |=>
         (rsp_valid && word_index == 3'($past(word_index) + 3'd1)))
      else $error("digest words out of sequence");

   a_end_digest: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && digest_last) |=> (!rsp_valid && req_ready))
      else $error("block not idle after final digest word");

   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(digest_word)))
      else $error("stalled digest word changed");

endmodule

bind sha256_stream_hash sha_check u_check (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .digest_word (rsp_chan.digest_word),
   .word_index  (rsp_chan.word_index),
   .digest_last (rsp_chan.digest_last)
);
